FILE: hw/rtl/wavhp_pkg.sv
// shared constants and types for the wav header parser
package wavhp_pkg;

  // header layout
  localparam int HDR_LEN    = 44;
  localparam int POS_W      = 6;
  localparam int WORD_W     = 32;

  localparam logic [POS_W-1:0] POS_RIFF  = 6'd3;
  localparam logic [POS_W-1:0] POS_WAVE  = 6'd11;
  localparam logic [POS_W-1:0] POS_FMT   = 6'd15;
  localparam logic [POS_W-1:0] POS_FMTCD = 6'd21;
  localparam logic [POS_W-1:0] POS_CHANS = 6'd23;
  localparam logic [POS_W-1:0] POS_RATE  = 6'd27;
  localparam logic [POS_W-1:0] POS_BITS  = 6'd35;
  localparam logic [POS_W-1:0] POS_DATA  = 6'd39;
  localparam logic [POS_W-1:0] POS_SIZE  = 6'd43;
  localparam logic [POS_W-1:0] POS_BODY  = 6'd44;

  // chunk tags as little-endian words
  localparam logic [WORD_W-1:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;
  localparam logic [15:0] FMT_PCM  = 16'd1;
  localparam logic [15:0] BITS_16  = 16'd16;

  localparam logic [WORD_W-1:0] RATE_RESET = 32'd48000;

  // divider widths: frames = (size / 2) / channels
  localparam int DIVIDEND_W = 31;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [3:0] {
    STAT_OK            = 4'd0,
    STAT_TOO_SHORT     = 4'd1,
    STAT_BAD_RIFF      = 4'd2,
    STAT_BAD_WAVE      = 4'd3,
    STAT_BAD_FMT_ID    = 4'd4,
    STAT_NOT_PCM       = 4'd5,
    STAT_BAD_RATE      = 4'd6,
    STAT_BAD_BITS      = 4'd7,
    STAT_BAD_DATA_ID   = 4'd8,
    STAT_ZERO_CHANNELS = 4'd9
  } status_t;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  // divider request and completion
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: hw/rtl/wavhp_div.sv
// restoring divider, one quotient bit per cycle
module wavhp_div (
  input  logic                clk,
  input  logic                rst,
  input  wavhp_pkg::div_req_t req,
  output wavhp_pkg::div_rsp_t rsp
);
  import wavhp_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  count;
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // trial subtract of the shifted remainder
  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= req.dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DIVISOR_W-1:0];
      end
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: hw/rtl/wav_header_parser.sv
// wav header parser: byte-wise header checks, one report, data pass-through
// latency: an accepted byte's result is in the output register in the next cycle,
// except a good header's report, which waits for the divider's frame count
// throughput: one byte per cycle while the output register is free or taken by m_tready;
// after a good header's last byte the input is held off while the divider forms the frame count one bit per cycle
// reset: synchronous, clears the file state and output, rate register to 48000
module wav_header_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [wavhp_pkg::IN_DATA_W-1:0]   s_tdata,  // data_byte
  input  logic                              s_tlast,  // final_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status[3:0], channel_total[19:4], frame_total[50:20], sample_byte[58:51]
  output logic [wavhp_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                              m_tuser,  // result_kind
  output logic                              m_tlast,  // last_result
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wavhp_pkg::WORD_W-1:0]      cfg_data  // expected_sample_rate
);
  import wavhp_pkg::*;

  typedef enum logic [1:0] {
    S_RUN = 2'b01,
    S_DIV = 2'b10
  } state_t;

  state_t              state;
  logic [WORD_W-1:0]   rate;
  logic [POS_W-1:0]    byte_position;
  logic [WORD_W-1:0]   word_shift;
  status_t             first_error;
  logic [15:0]         channel_reg;
  logic [WORD_W-1:0]   data_remaining;
  logic                pend_last;
  logic                pend_fin;

  logic                out_valid;
  logic                out_kind;
  status_t             out_status;
  logic [15:0]         out_chans;
  logic [DIVIDEND_W-1:0] out_frames;
  logic [7:0]          out_byte;
  logic                out_last;

  logic                accept;
  logic                in_body;
  logic [WORD_W-1:0]   word_shift_next;
  logic [WORD_W-1:0]   cmp_ref;
  logic [WORD_W-1:0]   cmp_mask;
  logic                cmp_en;
  status_t             cmp_code;
  logic                cmp_fail;
  status_t             first_error_next;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_RUN) && (!out_valid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign in_body   = byte_position >= POS_BODY;

  assign word_shift_next = {s_tdata, word_shift[WORD_W-1:8]};

  // field check selection per header position
  always_comb begin
    cmp_en   = 1'b1;
    cmp_ref  = '0;
    cmp_mask = '1;
    cmp_code = STAT_OK;
    case (byte_position)
      POS_RIFF:  begin cmp_ref = TAG_RIFF; cmp_code = STAT_BAD_RIFF;    end
      POS_WAVE:  begin cmp_ref = TAG_WAVE; cmp_code = STAT_BAD_WAVE;    end
      POS_FMT:   begin cmp_ref = TAG_FMT;  cmp_code = STAT_BAD_FMT_ID;  end
      POS_FMTCD: begin
        cmp_ref  = {FMT_PCM, 16'h0000};
        cmp_mask = 32'hFFFF_0000;
        cmp_code = STAT_NOT_PCM;
      end
      POS_RATE:  begin cmp_ref = rate;     cmp_code = STAT_BAD_RATE;    end
      POS_BITS:  begin
        cmp_ref  = {BITS_16, 16'h0000};
        cmp_mask = 32'hFFFF_0000;
        cmp_code = STAT_BAD_BITS;
      end
      POS_DATA:  begin cmp_ref = TAG_DATA; cmp_code = STAT_BAD_DATA_ID; end
      default:   cmp_en = 1'b0;
    endcase
  end

  // shared compare and first-error capture
  assign cmp_fail = (word_shift_next & cmp_mask) != cmp_ref;

  always_comb begin
    first_error_next = first_error;
    if (first_error == STAT_OK) begin
      if (cmp_en && cmp_fail) begin
        first_error_next = cmp_code;
      end else if (byte_position == POS_SIZE && channel_reg == '0) begin
        first_error_next = STAT_ZERO_CHANNELS;
      end
    end
  end

  // divider request at the end of a good header
  always_comb begin
    div_req.start    = accept && !in_body && byte_position == POS_SIZE &&
                       first_error_next == STAT_OK;
    div_req.dividend = word_shift_next[WORD_W-1:1];
    div_req.divisor  = channel_reg;
  end

  wavhp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rate <= cfg_data;
    end
  end

  // sequencer, file state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_RUN;
      byte_position  <= '0;
      word_shift     <= '0;
      first_error    <= STAT_OK;
      channel_reg    <= '0;
      data_remaining <= '0;
      pend_last      <= 1'b0;
      pend_fin       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_RUN: begin
          if (accept) begin
            if (in_body) begin
              // sample bytes after a good header
              if (data_remaining != '0) begin
                data_remaining <= data_remaining - 1'b1;
                out_valid      <= 1'b1;
                out_kind       <= KIND_SAMPLE;
                out_status     <= STAT_OK;
                out_chans      <= '0;
                out_frames     <= '0;
                out_byte       <= s_tdata;
                out_last       <= s_tlast || data_remaining == WORD_W'(1);
              end
              if (s_tlast) begin
                byte_position  <= '0;
                word_shift     <= '0;
                first_error    <= STAT_OK;
                channel_reg    <= '0;
                data_remaining <= '0;
              end
            end else if (byte_position == POS_SIZE) begin
              // header complete
              byte_position <= POS_BODY;
              word_shift    <= word_shift_next;
              first_error   <= first_error_next;
              if (first_error_next != STAT_OK) begin
                out_valid      <= 1'b1;
                out_kind       <= KIND_REPORT;
                out_status     <= first_error_next;
                out_chans      <= '0;
                out_frames     <= '0;
                out_byte       <= '0;
                out_last       <= 1'b1;
                data_remaining <= '0;
                if (s_tlast) begin
                  byte_position <= '0;
                  word_shift    <= '0;
                  first_error   <= STAT_OK;
                  channel_reg   <= '0;
                end
              end else begin
                data_remaining <= word_shift_next;
                pend_last      <= s_tlast || word_shift_next == '0;
                pend_fin       <= s_tlast;
                state          <= S_DIV;
              end
            end else if (s_tlast) begin
              // file ended inside the header
              out_valid      <= 1'b1;
              out_kind       <= KIND_REPORT;
              out_status     <= STAT_TOO_SHORT;
              out_chans      <= '0;
              out_frames     <= '0;
              out_byte       <= '0;
              out_last       <= 1'b1;
              byte_position  <= '0;
              word_shift     <= '0;
              first_error    <= STAT_OK;
              channel_reg    <= '0;
              data_remaining <= '0;
            end else begin
              byte_position <= byte_position + 1'b1;
              word_shift    <= word_shift_next;
              first_error   <= first_error_next;
              if (byte_position == POS_CHANS) begin
                channel_reg <= word_shift_next[WORD_W-1:16];
              end
            end
          end
        end
        S_DIV: begin
          // frame count ready: emit the good report
          if (div_rsp.done) begin
            state      <= S_RUN;
            out_valid  <= 1'b1;
            out_kind   <= KIND_REPORT;
            out_status <= STAT_OK;
            out_chans  <= channel_reg;
            out_frames <= div_rsp.quotient;
            out_byte   <= '0;
            out_last   <= pend_last;
            if (pend_fin) begin
              byte_position  <= '0;
              word_shift     <= '0;
              first_error    <= STAT_OK;
              channel_reg    <= '0;
              data_remaining <= '0;
            end
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

  // output stream
  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {5'b0, out_byte, out_frames, out_chans, out_status};

endmodule
